/* rtl/core/acsi_pkg.sv */
package acsi_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_HEAD,
        ST_BYTES
    } acsi_state_t;

    localparam logic [1:0] FUNC_SELECT = 2'd0;
    localparam logic [1:0] FUNC_CMD    = 2'd1;
    localparam logic [1:0] FUNC_WDONE  = 2'd2;

    localparam logic [1:0] STAT_GOOD  = 2'd0;
    localparam logic [1:0] STAT_CHECK = 2'd1;
    localparam logic [1:0] STAT_SHIP  = 2'd2;

    localparam logic [7:0] OP_TUR     = 8'h00;
    localparam logic [7:0] OP_RSENSE  = 8'h03;
    localparam logic [7:0] OP_FORMAT  = 8'h04;
    localparam logic [7:0] OP_READ6   = 8'h08;
    localparam logic [7:0] OP_WRITE6  = 8'h0A;
    localparam logic [7:0] OP_SEEK    = 8'h0B;
    localparam logic [7:0] OP_INQUIRY = 8'h12;
    localparam logic [7:0] OP_MSELECT = 8'h15;
    localparam logic [7:0] OP_MSENSE  = 8'h1A;
    localparam logic [7:0] OP_SHIP    = 8'h1B;
    localparam logic [7:0] OP_RDCAP   = 8'h25;
    localparam logic [7:0] OP_READ10  = 8'h28;
    localparam logic [7:0] OP_WRITE10 = 8'h2A;
    localparam logic [7:0] OP_RLUNS   = 8'hA0;

    localparam logic [7:0] SN_NONE    = 8'h00;
    localparam logic [7:0] SN_RDERR   = 8'h01;
    localparam logic [7:0] SN_WRERR   = 8'h03;
    localparam logic [7:0] SN_BADOP   = 8'h20;
    localparam logic [7:0] SN_RANGE   = 8'h21;
    localparam logic [7:0] SN_BADFLD  = 8'h24;
    localparam logic [7:0] SN_BADLUN  = 8'h25;
    localparam logic [7:0] SN_NOMED   = 8'h3A;

    typedef enum logic [2:0] {
        RSP_NONE,
        RSP_INQ,
        RSP_SENSE,
        RSP_CAP,
        RSP_MODE,
        RSP_LUNS
    } acsi_rsp_t;

    // per-target state word
    typedef struct packed {
        logic [7:0]  sense;
        logic        valid;
        logic [31:0] last;
    } acsi_tgt_t;

    // response generator setup
    typedef struct packed {
        acsi_rsp_t   kind;
        logic [6:0]  nbytes;
        logic [7:0]  page;
        logic        lun_nz;
        acsi_tgt_t   tgt;
        logic [31:0] sectors;
    } acsi_rsp_cfg_t;

    function automatic logic [7:0] inq_byte(input logic [5:0] i);
        logic [7:0] r;
        case (i)
            6'd2:  r = 8'd1;
            6'd4:  r = 8'd31;
            6'd8:  r = "D";
            6'd9:  r = "I";
            6'd10: r = "S";
            6'd11: r = "K";
            6'd12: r = "E";
            6'd13: r = "M";
            6'd14: r = "U";
            6'd15: r = " ";
            6'd16: r = "E";
            6'd17: r = "m";
            6'd18: r = "u";
            6'd19: r = "l";
            6'd20: r = "a";
            6'd21: r = "t";
            6'd22: r = "e";
            6'd23: r = "d";
            6'd24: r = "H";
            6'd25: r = "a";
            6'd26: r = "r";
            6'd27: r = "d";
            6'd28: r = "d";
            6'd29: r = "i";
            6'd30: r = "s";
            6'd31: r = "k";
            6'd32: r = "0";
            6'd33: r = "1";
            6'd34: r = "8";
            6'd35: r = "0";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/acsi_resp.sv */
module acsi_resp
    import acsi_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
) (
    input  logic          aclk,
    input  acsi_rsp_cfg_t cfg,
    input  logic [5:0]    idx,
    input  logic          en,
    output logic [7:0]    data
);

    localparam logic [31:0] SB = 32'(SECTOR_BYTES);

    acsi_rsp_cfg_t cfg_reg;
    logic [7:0] data_next;
    logic [31:0] cap;
    logic [31:0] a;
    logic [31:0] s;

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg;
    end

    function automatic logic [7:0] pvend(input logic [5:0] i, input logic [31:0] sc);
        logic [7:0] r;
        case (i)
            6'd1:  r = 8'd14;
            6'd3:  r = 8'd8;
            6'd5:  r = sc[23:16];
            6'd6:  r = sc[15:8];
            6'd7:  r = sc[7:0];
            6'd9:  r = SB[23:16];
            6'd10: r = SB[15:8];
            6'd11: r = SB[7:0];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pgeo(input logic [5:0] i, input logic [31:0] sc);
        logic [7:0] r;
        case (i)
            6'd0:  r = 8'd4;
            6'd1:  r = 8'd22;
            6'd2:  r = sc[30:23];
            6'd3:  r = sc[22:15];
            6'd4:  r = sc[14:7];
            6'd5:  r = 8'd128;
            6'd20: r = 8'h1c;
            6'd21: r = 8'h20;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    always_comb begin
        a = cfg_reg.tgt.last;
        s = cfg_reg.sectors;
        cap = s - 32'd1;
        data_next = 8'd0;
        case (cfg_reg.kind)
            RSP_INQ: begin
                if (idx == 6'd0) data_next = cfg_reg.lun_nz ? 8'h7F : 8'h00;
                else data_next = inq_byte(idx);
            end
            RSP_CAP: begin
                case (idx)
                    6'd0: data_next = cap[31:24];
                    6'd1: data_next = cap[23:16];
                    6'd2: data_next = cap[15:8];
                    6'd3: data_next = cap[7:0];
                    6'd4: data_next = SB[31:24];
                    6'd5: data_next = SB[23:16];
                    6'd6: data_next = SB[15:8];
                    6'd7: data_next = SB[7:0];
                    default: data_next = 8'd0;
                endcase
            end
            RSP_LUNS: data_next = (idx == 6'd3) ? 8'd8 : 8'd0;
            RSP_SENSE: begin
                if (cfg_reg.nbytes <= 7'd4) begin
                    case (idx)
                        6'd0: data_next = cfg_reg.tgt.sense | {cfg_reg.tgt.valid, 7'd0};
                        6'd1: data_next = cfg_reg.tgt.valid ? a[23:16] : 8'd0;
                        6'd2: data_next = cfg_reg.tgt.valid ? a[15:8] : 8'd0;
                        6'd3: data_next = cfg_reg.tgt.valid ? a[7:0] : 8'd0;
                        default: data_next = 8'd0;
                    endcase
                end else begin
                    case (idx)
                        6'd0: data_next = {cfg_reg.tgt.valid, 7'h70};
                        6'd2: begin
                            if (cfg_reg.tgt.sense == SN_NONE) data_next = 8'd0;
                            else if (cfg_reg.tgt.sense == SN_BADOP
                                || cfg_reg.tgt.sense == SN_RANGE
                                || cfg_reg.tgt.sense == SN_BADFLD
                                || cfg_reg.tgt.sense == SN_BADLUN) data_next = 8'd5;
                            else if (cfg_reg.tgt.sense == SN_NOMED) data_next = 8'd2;
                            else data_next = 8'd4;
                        end
                        6'd4: data_next = cfg_reg.tgt.valid ? a[23:16] : 8'd0;
                        6'd5: data_next = cfg_reg.tgt.valid ? a[15:8] : 8'd0;
                        6'd6: data_next = cfg_reg.tgt.valid ? a[7:0] : 8'd0;
                        6'd7: data_next = 8'd14;
                        6'd12: data_next = cfg_reg.tgt.sense;
                        6'd19: data_next = a[23:16];
                        6'd20: data_next = a[15:8];
                        6'd21: data_next = a[7:0];
                        default: data_next = 8'd0;
                    endcase
                end
            end
            RSP_MODE: begin
                if (cfg_reg.page == 8'h00) begin
                    data_next = (idx < 6'd16) ? pvend(idx, s) : 8'd0;
                end else begin
                    if (idx == 6'd0) data_next = (cfg_reg.page == 8'h04) ? 8'd24 : 8'd43;
                    else if (idx >= 6'd4 && idx < 6'd28) data_next = pgeo(idx - 6'd4, s);
                    else if (idx >= 6'd28 && cfg_reg.page == 8'h3F)
                        data_next = pvend(idx - 6'd28, s);
                    else data_next = 8'd0;
                end
            end
            default: data_next = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) data <= data_next;
    end

endmodule

/* rtl/core/acsi_scsi_target_command_engine.sv */
// Hard-disk target command engine. Select a target (func 0), then send command
// bytes (func 1); 6-, 10- and 12-byte packets execute on their last byte. Every
// input transfer yields one header result, followed for inquiry, request sense,
// read capacity, mode sense and report LUNs by up to MAX_RESP_BYTES response
// byte transfers. Per-target sense code, address-valid and last block live in
// a small synchronous memory that each item reads and may write back once. A
// command byte, write-phase or unused-code item passes through accept, memory
// read, execute and header states, and a select through accept and header; a
// response then sends its bytes from a registered byte generator. The single
// memory port and the one-item sequencer take no new item until the last is
// done; a stalled output holds them. The output register holds a result until taken.
module acsi_scsi_target_command_engine
    import acsi_pkg::*;
#(
    parameter int NUM_TARGETS    = 8,
    parameter int CMD_BYTES      = 12,
    parameter int SECTOR_BYTES   = 512,
    parameter int MAX_RESP_BYTES = 44
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // func[1:0], value[9:2], zero[15:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status_code[1:0], executed[2], data_len[27:3],
                                   // dma_write[28], block_addr[60:29], has_byte[61],
                                   // resp_byte[69:62], zero[71:70]
    output logic        m_tlast
);

    localparam int CW = $clog2(CMD_BYTES);

    logic [7:0]  present_reg, ro_reg;
    logic [63:0] sect_reg [4];

    acsi_state_t state_reg, state_next;
    logic [2:0]  sel_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  op_reg;
    logic [1:0]  stat_reg;
    logic [7:0]  cmd_reg [CMD_BYTES];
    logic [1:0]  func_reg;
    logic [7:0]  val_reg;

    acsi_tgt_t   tmem [8];
    acsi_tgt_t   trd_reg;
    logic        twe;
    acsi_tgt_t   twd;

    logic        exe_reg;
    logic [24:0] dlen_reg;
    logic        dwr_reg;
    logic [31:0] baddr_reg;
    logic [6:0]  nb_reg;
    logic [6:0]  bi_reg;
    acsi_rsp_cfg_t rcfg, rcfg_reg;
    logic [7:0]  rdata;

    logic [71:0] mdata_reg;
    logic        mvalid_reg, mlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            ro_reg <= '0;
            for (int i = 0; i < 4; i++) sect_reg[i] <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                3'd0: present_reg <= cfg_data[7:0];
                3'd1: ro_reg <= cfg_data[7:0];
                3'd2, 3'd3, 3'd4, 3'd5: sect_reg[cfg_index[1:0] - 2'd2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [1:0] func_in;
    logic [7:0] val_in;
    assign func_in = s_tdata[1:0];
    assign val_in  = s_tdata[9:2];
    assign s_tready = (state_reg == ST_IDLE) && aresetn;

    logic [31:0] secs;
    logic        tgt_ok, present;
    assign secs = sel_reg[0] ? sect_reg[sel_reg[2:1]][63:32] : sect_reg[sel_reg[2:1]][31:0];
    assign tgt_ok = 32'(sel_reg) < NUM_TARGETS;
    assign present = tgt_ok && present_reg[sel_reg];

    // target memory: read in ST_READ, write back in ST_EXEC
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) tmem[i] <= '0;
        end else if (twe) begin
            tmem[sel_reg] <= twd;
        end
        trd_reg <= tmem[sel_reg];
    end

    // execute
    logic [3:0]  cnt_n;
    logic [7:0]  op_n;
    logic [1:0]  stat_n;
    logic        exe_n, dwr_n;
    logic [24:0] dlen_n;
    logic [31:0] baddr_n;
    logic [31:0] lba, cnt32, dlen32;
    logic        done, lun_nz, wr, rsp;
    acsi_tgt_t   t_n;
    acsi_rsp_t   kind_n;

    always_comb begin
        cnt_n = cnt_reg;
        op_n = op_reg;
        stat_n = stat_reg;
        exe_n = 1'b0;
        dwr_n = 1'b0;
        dlen32 = '0;
        baddr_n = '0;
        t_n = trd_reg;
        twe = 1'b0;
        kind_n = RSP_NONE;
        rsp = 1'b0;
        done = 1'b0;
        lun_nz = cmd_reg[1][7:5] != 3'd0;
        wr = 1'b0;
        lba = '0;
        cnt32 = '0;
        if (func_reg == FUNC_WDONE) begin
            if (!tgt_ok) stat_n = STAT_CHECK;
            else if (!present_reg[sel_reg] || ro_reg[sel_reg]) begin
                stat_n = STAT_CHECK;
                t_n.sense = SN_WRERR;
                twe = 1'b1;
            end
        end else if (func_reg == FUNC_CMD) begin
            if (!present) begin
                stat_n = STAT_CHECK;
            end else begin
                if (cnt_reg == 4'd0) op_n = val_reg;
                if (cnt_reg != 4'd15) cnt_n = cnt_reg + 4'd1;
                done = (op_n < 8'h20 && cnt_n == 4'd6) ||
                       (op_n >= 8'h20 && op_n < 8'h60 && cnt_n == 4'd10) ||
                       (op_n == OP_RLUNS && cnt_n == 4'd12);
                lba = (op_n < 8'h20) ? {11'd0, cmd_reg[1][4:0], cmd_reg[2], cmd_reg[3]}
                                     : {cmd_reg[2], cmd_reg[3], cmd_reg[4], cmd_reg[5]};
                if (op_n < 8'h20)
                    cnt32 = ((op_n == OP_READ6 || op_n == OP_WRITE6) && cmd_reg[4] == 8'd0)
                          ? 32'd256 : {24'd0, cmd_reg[4]};
                else cnt32 = {16'd0, cmd_reg[7], cmd_reg[8]};
                wr = (op_n == OP_WRITE6 || op_n == OP_WRITE10);
                if (done) begin
                    twe = 1'b1;
                    if (!lun_nz || op_n == OP_INQUIRY) begin
                        exe_n = 1'b1;
                        unique case (op_n)
                            OP_TUR: stat_n = STAT_GOOD;
                            OP_RDCAP: begin
                                dlen32 = 32'd8; kind_n = RSP_CAP;
                                stat_n = STAT_GOOD; t_n.sense = SN_NONE; t_n.valid = 1'b0;
                            end
                            OP_READ6, OP_READ10, OP_WRITE6, OP_WRITE10: begin
                                t_n.last = lba; baddr_n = lba; t_n.valid = 1'b1;
                                stat_n = STAT_CHECK;
                                if (!present) t_n.sense = wr ? SN_WRERR : SN_RDERR;
                                else if (lba >= secs || cnt32 > secs - lba) t_n.sense = SN_RANGE;
                                else if (wr && cnt32 == 32'd0) t_n.sense = SN_WRERR;
                                else begin
                                    dlen32 = cnt32 * 32'(SECTOR_BYTES);
                                    dwr_n = wr; stat_n = STAT_GOOD; t_n.sense = SN_NONE;
                                end
                            end
                            OP_SEEK: begin
                                t_n.last = lba; baddr_n = lba; t_n.valid = 1'b1;
                                if (present && lba < secs) begin
                                    stat_n = STAT_GOOD; t_n.sense = SN_NONE;
                                end else begin
                                    stat_n = STAT_CHECK; t_n.sense = SN_RANGE;
                                end
                            end
                            OP_INQUIRY: begin
                                dlen32 = {24'd0, cmd_reg[4]}; kind_n = RSP_INQ;
                                stat_n = STAT_GOOD; t_n.sense = SN_NONE; t_n.valid = 1'b0;
                            end
                            OP_SHIP: stat_n = STAT_SHIP;
                            OP_RSENSE: begin
                                kind_n = RSP_SENSE; stat_n = STAT_GOOD;
                                if (cmd_reg[4] == 8'd0) dlen32 = 32'd4;
                                else if (cmd_reg[4] > 8'd22) dlen32 = 32'd22;
                                else dlen32 = {24'd0, cmd_reg[4]};
                            end
                            OP_MSELECT, OP_FORMAT: begin
                                stat_n = STAT_GOOD; t_n.sense = SN_NONE; t_n.valid = 1'b0;
                            end
                            OP_MSENSE: begin
                                t_n.valid = 1'b0;
                                if (cmd_reg[3] != 8'd0 || !(cmd_reg[2] == 8'h00
                                    || cmd_reg[2] == 8'h04 || cmd_reg[2] == 8'h3F)) begin
                                    stat_n = STAT_CHECK; t_n.sense = SN_BADFLD;
                                end else begin
                                    kind_n = RSP_MODE; stat_n = STAT_GOOD; t_n.sense = SN_NONE;
                                    dlen32 = (cmd_reg[2] == 8'h00) ? 32'd16 :
                                             (cmd_reg[2] == 8'h04) ? 32'd28 : 32'd44;
                                    if ({24'd0, cmd_reg[4]} < dlen32) dlen32 = {24'd0, cmd_reg[4]};
                                end
                            end
                            OP_RLUNS: begin
                                dlen32 = 32'd16; kind_n = RSP_LUNS;
                                stat_n = STAT_GOOD; t_n.sense = SN_NONE; t_n.valid = 1'b0;
                            end
                            default: begin
                                stat_n = STAT_CHECK; t_n.sense = SN_BADOP; t_n.valid = 1'b0;
                            end
                        endcase
                    end else begin
                        t_n.sense = SN_BADLUN;
                        if (op_n == OP_RSENSE) begin
                            exe_n = 1'b1; kind_n = RSP_SENSE; stat_n = STAT_GOOD;
                            if (cmd_reg[4] == 8'd0) dlen32 = 32'd4;
                            else if (cmd_reg[4] > 8'd22) dlen32 = 32'd22;
                            else dlen32 = {24'd0, cmd_reg[4]};
                        end else stat_n = STAT_CHECK;
                    end
                end else if (op_n >= 8'h60 && op_n != OP_RLUNS) begin
                    stat_n = STAT_CHECK; t_n.sense = SN_BADOP; t_n.valid = 1'b0; twe = 1'b1;
                end else stat_n = STAT_GOOD;
            end
        end
        rsp = kind_n != RSP_NONE;
        dlen_n = dlen32[24:0];
        twd = t_n;
        // a sense response reads the state as it stood before the write-back; a nonzero LUN reports the bad-LUN code
        rcfg.kind = kind_n;
        rcfg.nbytes = !rsp ? 7'd0 :
                      (dlen32 < 32'(MAX_RESP_BYTES)) ? dlen32[6:0] : 7'(MAX_RESP_BYTES);
        rcfg.page = cmd_reg[2];
        rcfg.lun_nz = lun_nz;
        rcfg.tgt = (kind_n == RSP_SENSE) ? trd_reg : t_n;
        rcfg.tgt.sense = (kind_n == RSP_SENSE && lun_nz) ? SN_BADLUN : rcfg.tgt.sense;
        rcfg.sectors = secs;
        if (state_reg != ST_EXEC) twe = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            func_reg <= func_in;
            val_reg <= val_in;
        end
        if (!aresetn) begin
            for (int i = 0; i < CMD_BYTES; i++) cmd_reg[i] <= '0;
        end else if (state_reg == ST_EXEC && func_reg == FUNC_CMD && present
            && 32'(cnt_reg) < CMD_BYTES && cnt_reg != 4'd15) begin
            cmd_reg[cnt_reg[CW-1:0]] <= val_reg;
        end
        if (state_reg == ST_EXEC) begin
            exe_reg <= exe_n;
            dlen_reg <= dlen_n;
            dwr_reg <= dwr_n;
            baddr_reg <= baddr_n;
            nb_reg <= rcfg.nbytes;
            rcfg_reg <= rcfg;
        end else if (state_reg == ST_IDLE && s_tvalid && func_in == FUNC_SELECT) begin
            exe_reg <= 1'b0; dlen_reg <= '0; dwr_reg <= 1'b0;
            baddr_reg <= '0; nb_reg <= '0;
        end
    end

    logic mfree;
    logic fetch;
    assign mfree = !mvalid_reg || m_tready;
    assign fetch = (state_reg == ST_BYTES) && mfree && bi_reg != nb_reg;

    acsi_resp #(.SECTOR_BYTES(SECTOR_BYTES)) u_resp (
        .aclk (aclk),
        .cfg  (rcfg_reg),
        .idx  (bi_reg[5:0]),
        .en   (fetch),
        .data (rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = (func_in == FUNC_SELECT) ? ST_HEAD : ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_HEAD;
            ST_HEAD:  if (mfree)
                          state_next = (nb_reg == 7'd0 || func_reg != FUNC_CMD) ? ST_IDLE : ST_BYTES;
            ST_BYTES: if (bi_reg == nb_reg && mfree) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic rpend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg <= '0;
            cnt_reg <= '0;
            op_reg <= '0;
            stat_reg <= '0;
            mvalid_reg <= 1'b0;
            mlast_reg <= 1'b0;
            bi_reg <= '0;
            rpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_tvalid && func_in == FUNC_SELECT) begin
                sel_reg <= val_in[2:0];
                cnt_reg <= '0;
            end
            if (state_reg == ST_EXEC) begin
                cnt_reg <= cnt_n; op_reg <= op_n; stat_reg <= stat_n;
            end
            if (state_reg == ST_HEAD && mfree) begin
                mvalid_reg <= 1'b1;
                mdata_reg <= {2'd0, 8'd0, 1'b0, baddr_reg, dwr_reg, dlen_reg, exe_reg, stat_reg};
                mlast_reg <= (nb_reg == 7'd0) || func_reg != FUNC_CMD;
                bi_reg <= '0;
                rpend_reg <= 1'b0;
            end else if (state_reg == ST_BYTES && rpend_reg && mfree) begin
                mvalid_reg <= 1'b1;
                mdata_reg <= {2'd0, rdata, 1'b1, 61'd0};
                mlast_reg <= bi_reg == nb_reg;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
            if (state_reg == ST_BYTES) begin
                if (mfree) rpend_reg <= fetch;
                if (fetch) bi_reg <= bi_reg + 7'd1;
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mvalid_reg || state_reg == ST_IDLE)
        else $error("input taken outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BYTES |-> bi_reg <= nb_reg)
        else $error("byte index overran");
    assert property (@(posedge aclk) disable iff (!aresetn)
        nb_reg <= 7'(MAX_RESP_BYTES))
        else $error("response count too large");

endmodule

/* test/acsi_scsi_target_command_engine_tb.sv */
module acsi_scsi_target_command_engine_tb;
    import acsi_pkg::*;

    localparam int          SECT_BYTES = 512;
    localparam int          RESP_MAX   = 44;
    localparam logic [223:0] ID_TEXT   = "DISKEMU EmulatedHarddisk0180";

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    acsi_scsi_target_command_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // shadow of the block
    logic [7:0]  pm, rom;
    logic [63:0] sect [4];
    logic [2:0]  sel;
    logic [3:0]  bcnt;
    logic [7:0]  cmd [12];
    logic [7:0]  opc;
    logic [1:0]  stat;
    logic [7:0]  sense [8];
    logic        av [8];
    logic [31:0] lastb [8];
    logic [7:0]  rb [64];
    logic [31:0] e_dlen, e_baddr;
    logic        e_dwr, e_has, e_exe;

    logic [9:0]  cmd_items [$];
    logic [72:0] result_q [$];
    logic [9:0]  cur_item;
    int          src_idle = 0, snk_idle = 0;
    int          errors = 0;

    function automatic logic [31:0] sectors_of(input logic [2:0] t);
        logic [63:0] w;
        w = sect[t[2:1]];
        return t[0] ? w[63:32] : w[31:0];
    endfunction

    task set_res(input logic [2:0] t, input logic [1:0] st, input logic [7:0] sn,
                 input logic v);
        stat = st;
        sense[t] = sn;
        av[t] = v;
    endtask

    task req_sense(input logic [2:0] t);
        logic [31:0] n, a;
        logic [7:0]  s;
        n = cmd[4];
        a = lastb[t];
        s = sense[t];
        if (n == 0) n = 4;
        else if (n > 22) n = 22;
        if (n <= 4) begin
            rb[0] = s;
            if (av[t]) begin
                rb[0] = rb[0] | 8'h80;
                rb[1] = a[23:16]; rb[2] = a[15:8]; rb[3] = a[7:0];
            end
        end else begin
            rb[0] = 8'h70;
            if (av[t]) begin
                rb[0] = 8'hF0;
                rb[4] = a[23:16]; rb[5] = a[15:8]; rb[6] = a[7:0];
            end
            if (s == SN_NONE) rb[2] = 0;
            else if (s == SN_BADOP || s == SN_RANGE || s == SN_BADFLD || s == SN_BADLUN)
                rb[2] = 5;
            else if (s == SN_NOMED) rb[2] = 2;
            else rb[2] = 4;
            rb[7] = 14;
            rb[12] = s;
            rb[19] = a[23:16]; rb[20] = a[15:8]; rb[21] = a[7:0];
        end
        e_dlen = n;
        e_has = 1;
        stat = STAT_GOOD;
    endtask

    task page_vendor(input int o, input logic [31:0] s);
        logic [31:0] sb;
        sb = SECT_BYTES;
        rb[o+1] = 14; rb[o+3] = 8;
        rb[o+5] = s[23:16]; rb[o+6] = s[15:8]; rb[o+7] = s[7:0];
        rb[o+9] = sb[23:16]; rb[o+10] = sb[15:8]; rb[o+11] = sb[7:0];
    endtask

    task page_geometry(input int o, input logic [31:0] s);
        rb[o] = 4; rb[o+1] = 22;
        rb[o+2] = s[30:23]; rb[o+3] = s[22:15]; rb[o+4] = s[14:7];
        rb[o+5] = 128;
        rb[o+20] = 8'h1c; rb[o+21] = 8'h20;
    endtask

    task execute(input logic [2:0] t);
        logic [31:0] s, a, c, len, sb;
        logic        wr;
        s = sectors_of(t);
        sb = SECT_BYTES;
        case (opc)
            OP_TUR: stat = STAT_GOOD;
            OP_RDCAP: begin
                a = s - 1;
                {rb[0], rb[1], rb[2], rb[3]} = a;
                {rb[4], rb[5], rb[6], rb[7]} = sb;
                e_dlen = 8; e_has = 1;
                set_res(t, STAT_GOOD, SN_NONE, 0);
            end
            OP_READ6, OP_READ10, OP_WRITE6, OP_WRITE10, OP_SEEK: begin
                wr = (opc == OP_WRITE6 || opc == OP_WRITE10);
                if (opc < 8'h20) a = {cmd[1], cmd[2], cmd[3]} & 32'h1FFFFF;
                else a = {cmd[2], cmd[3], cmd[4], cmd[5]};
                if (opc < 8'h20)
                    c = (opc != OP_SEEK && cmd[4] == 0) ? 32'd256 : {24'd0, cmd[4]};
                else c = {16'd0, cmd[7], cmd[8]};
                lastb[t] = a; e_baddr = a;
                if (opc == OP_SEEK) begin
                    if (pm[t] && a < s) set_res(t, STAT_GOOD, SN_NONE, 1);
                    else set_res(t, STAT_CHECK, SN_RANGE, 1);
                end else if (!pm[t]) set_res(t, STAT_CHECK, wr ? SN_WRERR : SN_RDERR, 1);
                else if (a >= s || c > s - a) set_res(t, STAT_CHECK, SN_RANGE, 1);
                else if (wr && c == 0) set_res(t, STAT_CHECK, SN_WRERR, 1);
                else begin
                    e_dlen = c * sb;
                    e_dwr = wr;
                    set_res(t, STAT_GOOD, SN_NONE, 1);
                end
            end
            OP_INQUIRY: begin
                for (int k = 0; k < 28; k++) rb[8+k] = ID_TEXT[8*(27-k) +: 8];
                rb[0] = (cmd[1][7:5] == 0) ? 8'h00 : 8'h7F;
                rb[2] = 1; rb[4] = 31;
                e_dlen = cmd[4]; e_has = 1;
                set_res(t, STAT_GOOD, SN_NONE, 0);
            end
            OP_SHIP: stat = STAT_SHIP;
            OP_RSENSE: req_sense(t);
            OP_MSELECT, OP_FORMAT: set_res(t, STAT_GOOD, SN_NONE, 0);
            OP_MSENSE: begin
                av[t] = 0;
                len = 0;
                if (cmd[3] != 0) begin
                    stat = STAT_CHECK; sense[t] = SN_BADFLD;
                end else begin
                    case (cmd[2])
                        8'h00: begin len = 16; page_vendor(0, s); end
                        8'h04: begin len = 28; page_geometry(4, s); rb[0] = 24; end
                        8'h3F: begin
                            len = 44; page_geometry(4, s); page_vendor(28, s); rb[0] = 43;
                        end
                        default: begin stat = STAT_CHECK; sense[t] = SN_BADFLD; end
                    endcase
                    if (len != 0) begin
                        e_dlen = (len < cmd[4]) ? len : cmd[4];
                        e_has = 1;
                        stat = STAT_GOOD;
                        sense[t] = SN_NONE;
                    end
                end
            end
            OP_RLUNS: begin
                rb[3] = 8;
                e_dlen = 16; e_has = 1;
                set_res(t, STAT_GOOD, SN_NONE, 0);
            end
            default: set_res(t, STAT_CHECK, SN_BADOP, 0);
        endcase
    endtask

    task feed(input logic [7:0] b);
        logic [2:0] t;
        logic       done;
        t = sel;
        if (!pm[t]) begin
            stat = STAT_CHECK;
        end else begin
            if (bcnt == 0) opc = b;
            if (bcnt < 12) cmd[bcnt] = b;
            if (bcnt < 15) bcnt = bcnt + 1;
            done = (opc < 8'h20 && bcnt == 6) || (opc >= 8'h20 && opc < 8'h60 && bcnt == 10)
                || (opc == OP_RLUNS && bcnt == 12);
            if (done) begin
                if (cmd[1][7:5] == 0 || opc == OP_INQUIRY) begin
                    execute(t); e_exe = 1;
                end else begin
                    sense[t] = SN_BADLUN;
                    if (opc == OP_RSENSE) begin
                        req_sense(t); e_exe = 1;
                    end else stat = STAT_CHECK;
                end
            end else if (opc >= 8'h60 && opc != OP_RLUNS) begin
                set_res(t, STAT_CHECK, SN_BADOP, 0);
            end else begin
                stat = STAT_GOOD;
            end
        end
    endtask

    task predict_results(input logic [9:0] it);
        int unsigned nb;
        e_dlen = 0; e_baddr = 0; e_dwr = 0; e_has = 0; e_exe = 0;
        for (int k = 0; k < 64; k++) rb[k] = 0;
        case (it[1:0])
            FUNC_SELECT: begin sel = it[4:2]; bcnt = 0; end
            FUNC_CMD: feed(it[9:2]);
            FUNC_WDONE: begin
                if (!pm[sel] || rom[sel]) begin
                    stat = STAT_CHECK; sense[sel] = SN_WRERR;
                end
            end
            default: ;
        endcase
        nb = e_has ? ((e_dlen < RESP_MAX) ? e_dlen : RESP_MAX) : 0;
        result_q.push_back({nb == 0, 2'b0, 8'd0, 1'b0, e_baddr, e_dwr, e_dlen[24:0],
                            e_exe, stat});
        for (int unsigned i = 0; i < nb; i++)
            result_q.push_back({i + 1 == nb, 2'b0, rb[i], 1'b1, 32'd0, 1'b0, 25'd0,
                                1'b0, 2'b0});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_results(cur_item);
            if (!s_tvalid || s_tready) begin
                if (cmd_items.size() > 0 && $urandom_range(99) >= src_idle) begin
                    cur_item = cmd_items.pop_front();
                    s_tdata <= {6'd0, cur_item};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        logic [72:0] exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h last %b", m_tdata, m_tlast);
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r != {m_tlast, m_tdata}) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected data %h last %b, got data %h last %b",
                                     exp_r[71:0], exp_r[72], m_tdata, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    task push_item(input logic [1:0] f, input logic [7:0] v);
        cmd_items.push_back({v, f});
    endtask

    task cfg_write(input logic [2:0] idx, input logic [63:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        if (idx == 0) pm = d[7:0];
        else if (idx == 1) rom = d[7:0];
        else sect[idx-2] = d;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sectors();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFFFFFF;
            3: return $urandom;
            default: return $urandom_range(300, 2);
        endcase
    endfunction

    task send_packet(input logic [7:0] op, input int len, input logic lun_bad);
        logic [7:0] b [16];
        for (int k = 0; k < 16; k++) b[k] = $urandom;
        b[0] = op;
        b[1] = lun_bad ? {3'($urandom_range(7, 1)), 5'($urandom)} : {3'd0, 5'($urandom)};
        if ($urandom_range(3) != 0) begin
            b[1][4:0] = 0; b[2] = 0; b[3] = $urandom_range(255);
            if (op >= 8'h20) begin b[3] = 0; b[4] = 0; b[5] = $urandom_range(255); end
            if (op < 8'h20 && $urandom_range(1)) b[4] = $urandom_range(8);
            b[7] = 0; b[8] = $urandom_range(8);
        end
        if (op == OP_MSENSE) begin
            case ($urandom_range(4))
                0: b[2] = 8'h00;
                1: b[2] = 8'h04;
                2: b[2] = 8'h3F;
                default: b[2] = $urandom;
            endcase
            if ($urandom_range(4) != 0) b[3] = 0;
        end
        for (int k = 0; k < len; k++) push_item(FUNC_CMD, b[k]);
    endtask

    function automatic int packet_len(input logic [7:0] op);
        if (op < 8'h20) return 6;
        if (op < 8'h60) return 10;
        if (op == OP_RLUNS) return 12;
        return $urandom_range(8, 1);
    endfunction

    task random_items(input int count);
        logic [7:0] ops [14];
        logic [7:0] op;
        int         len;
        ops = '{OP_TUR, OP_RSENSE, OP_FORMAT, OP_READ6, OP_WRITE6, OP_SEEK, OP_INQUIRY,
                OP_MSELECT, OP_MSENSE, OP_SHIP, OP_RDCAP, OP_READ10, OP_WRITE10, OP_RLUNS};
        while (cmd_items.size() < count) begin
            case ($urandom_range(19))
                0: push_item(2'd3, $urandom);
                1: push_item(FUNC_WDONE, $urandom);
                2: push_item(FUNC_SELECT, $urandom);
                3: push_item(FUNC_CMD, $urandom);
                default: begin
                    if ($urandom_range(1)) push_item(FUNC_SELECT, $urandom);
                    op = ($urandom_range(9) == 0) ? 8'($urandom) : ops[$urandom_range(13)];
                    len = packet_len(op);
                    if ($urandom_range(9) == 0) len = $urandom_range(16, 1);
                    send_packet(op, len, $urandom_range(11) == 0);
                end
            endcase
        end
    endtask

    task directed_items();
        push_item(FUNC_SELECT, 8'h00);
        send_packet(OP_TUR, 6, 0);
        push_item(FUNC_SELECT, 8'h00);
        push_item(FUNC_CMD, OP_INQUIRY); push_item(FUNC_CMD, 8'h00);
        push_item(FUNC_CMD, 8'h00); push_item(FUNC_CMD, 8'h00);
        push_item(FUNC_CMD, 8'hFF); push_item(FUNC_CMD, 8'h00);
        push_item(FUNC_SELECT, 8'hF9);
        send_packet(OP_INQUIRY, 6, 1);
        push_item(FUNC_SELECT, 8'h01);
        send_packet(OP_READ6, 6, 0);
        push_item(FUNC_SELECT, 8'h01);
        send_packet(OP_RSENSE, 6, 1);
        push_item(FUNC_SELECT, 8'h02);
        send_packet(8'h7E, 3, 0);
        push_item(FUNC_SELECT, 8'h03);
        push_item(FUNC_CMD, OP_MSENSE); push_item(FUNC_CMD, 8'h00);
        push_item(FUNC_CMD, 8'h3F); push_item(FUNC_CMD, 8'h00);
        push_item(FUNC_CMD, 8'hFF); push_item(FUNC_CMD, 8'h00);
        push_item(FUNC_WDONE, 8'h00);
        push_item(2'd3, 8'hFF);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("acsi_scsi_target_command_engine regression: fail");
        $finish;
    end

    initial begin
        logic [7:0] pmv, rov;
        for (int k = 0; k < 8; k++) begin
            sense[k] = 0; av[k] = 0; lastb[k] = 0;
        end
        for (int k = 0; k < 12; k++) cmd[k] = 0;
        for (int k = 0; k < 4; k++) sect[k] = 0;
        pm = 0; rom = 0; sel = 0; bcnt = 0; opc = 0; stat = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            src_idle = (ph < 2) ? 34 : (ph < 4) ? 45 : 0;
            snk_idle = (ph < 2) ? 45 : (ph < 4) ? 34 : 0;
            case (ph)
                0: begin pmv = 8'hFF; rov = 8'h0F; end
                1: begin pmv = 8'h00; rov = 8'hFF; end
                2: begin pmv = 8'hFF; rov = 8'h00; end
                default: begin pmv = $urandom | 8'h11; rov = $urandom; end
            endcase
            cfg_write(0, {56'd0, pmv});
            cfg_write(1, {56'd0, rov});
            for (int k = 2; k < 6; k++) begin
                if (ph == 1) cfg_write(k, 64'hFFFFFFFF_FFFFFFFF);
                else cfg_write(k, {pick_sectors(), pick_sectors()});
            end
            if (ph == 0) directed_items();
            random_items((ph == 1) ? 30 : 75);
            wait (cmd_items.size() == 0 && !s_tvalid && result_q.size() == 0);
            repeat (60) @(posedge aclk);
        end
        if (errors == 0) $display("acsi_scsi_target_command_engine regression: pass");
        else $display("acsi_scsi_target_command_engine regression: fail");
        $finish;
    end

endmodule

/* acsi_scsi_target_command_engine.f */
rtl/core/acsi_pkg.sv
rtl/core/acsi_resp.sv
rtl/core/acsi_scsi_target_command_engine.sv
test/acsi_scsi_target_command_engine_tb.sv
